### src/twc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator package
// Shared widths, register indexes, the queue entry type and the saturating
// window-sum add.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int SUM_BITS   = 40;
  localparam int COUNT_BITS = 17;
  localparam int FRAC_BITS  = 8;
  localparam int CORR_BITS  = 35;
  localparam int NUM_BITS   = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS  = $clog2(NUM_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_TIME  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_TIME = 2'd2;

  localparam int FIRST_TIME_RESET  = 100;
  localparam int SECOND_TIME_RESET = 1000;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] value;
    logic                       first_hit;
    logic                       second_hit;
    logic                       last;
    logic                       lockin;
  } twc_entry_t;

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] a,
    input logic signed [SUM_BITS-1:0] b
  );
    logic [SUM_BITS:0] s;
    s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    return s[SUM_BITS-1:0];
  endfunction

endpackage

### src/twc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator channels
// Valid/ready stream interfaces for the sample input and the result output.
// ----------------------------------------------------------------------------
interface twc_sample_if #(
  parameter int SAMPLE_BITS = 24,
  parameter int TIME_BITS   = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic        [TIME_BITS-1:0]   sample_time;
  logic                          last_sample;

  modport source (output valid, sample_value, sample_time, last_sample, input ready);
  modport sink (input valid, sample_value, sample_time, last_sample, output ready);
endinterface

interface twc_result_if import twc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [CORR_BITS-1:0] correlation;
  logic                        empty_window;

  modport source (output valid, correlation, empty_window, input ready);
  modport sink (input valid, correlation, empty_window, output ready);
endinterface

### src/twc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator front end
// Holds the configuration registers and decides which window each incoming
// sample belongs to before handing it to the queue.
// ----------------------------------------------------------------------------
module twc_front import twc_pkg::*; #(
  parameter int SAMPLE_BITS  = 24,
  parameter int TIME_BITS    = 16,
  parameter int BOXCAR_WIDTH = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]      cfg_data,
  twc_sample_if.sink                samples,
  output logic                      push_valid,
  input  logic                      push_ready,
  output twc_entry_t                push_data
);

  // Wide enough for a window end past the time range, so bounds never wrap.
  localparam int EW = ((TIME_BITS > 13) ? TIME_BITS : 13) + 1;

  logic                 mode;
  logic [TIME_BITS-1:0] first_time;
  logic [TIME_BITS-1:0] second_time;

  logic [EW-1:0] t;
  logic [EW-1:0] t1;
  logic [EW-1:0] t2;
  logic [EW-1:0] mid;
  logic          box_first;
  logic          box_second;
  logic          lock_first;
  logic          lock_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      first_time  <= TIME_BITS'(FIRST_TIME_RESET);
      second_time <= TIME_BITS'(SECOND_TIME_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:        mode        <= cfg_data[0];
        REG_FIRST_TIME:  first_time  <= cfg_data;
        REG_SECOND_TIME: second_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    t   = EW'(samples.sample_time);
    t1  = EW'(first_time);
    t2  = EW'(second_time);
    mid = (t2 >= t1) ? t1 + ((t2 - t1) >> 1) : t1;

    box_first   = (t >= t1) && (t < t1 + EW'(BOXCAR_WIDTH));
    box_second  = (t >= t2) && (t < t2 + EW'(BOXCAR_WIDTH));
    lock_first  = (t >= t1) && (t < mid);
    lock_second = (t >= mid) && (t < t2);

    push_data.value      = SUM_BITS'($signed(samples.sample_value[SAMPLE_BITS-1:0]));
    push_data.first_hit  = mode ? lock_first : box_first;
    push_data.second_hit = mode ? lock_second : box_second;
    push_data.last       = samples.last_sample;
    push_data.lockin     = mode;
  end

  assign push_valid    = samples.valid;
  assign samples.ready = push_ready;

endmodule

### src/twc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator queue
// Short first-in first-out buffer between the classifying front end and the
// accumulating back end.
// ----------------------------------------------------------------------------
module twc_queue import twc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  twc_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output twc_entry_t pop_data
);

  twc_entry_t           mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/twc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator divider
// Restoring unsigned divider, one quotient bit per cycle, for the window means.
// ----------------------------------------------------------------------------
module twc_div import twc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  busy,
  output logic [NUM_BITS-1:0]   quotient
);

  logic [COUNT_BITS-1:0] den;
  logic [COUNT_BITS-1:0] rem;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  assign trial    = {rem, quotient[NUM_BITS-1]};
  assign fits     = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == STEP_BITS'(NUM_BITS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
      step     <= '0;
    end else if (busy) begin
      rem      <= fits ? COUNT_BITS'(trial - {1'b0, den}) : trial[COUNT_BITS-1:0];
      quotient <= {quotient[NUM_BITS-2:0], fits};
      step     <= step + 1'b1;
    end
  end

endmodule

### src/twc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator back end
// Accumulates window sums and counts, divides at the end of a transient when
// both windows hold samples, and holds the result in the output register.
// ----------------------------------------------------------------------------
module twc_back import twc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  twc_entry_t pop_data,
  twc_result_if.source results
);

  typedef enum logic [3:0] {
    S_ACCUM  = 4'b0001,
    S_START  = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } back_state_t;

  back_state_t state;

  logic signed [SUM_BITS-1:0]  first_sum;
  logic signed [SUM_BITS-1:0]  second_sum;
  logic [COUNT_BITS-1:0]       first_count;
  logic [COUNT_BITS-1:0]       second_count;
  logic                        lockin;
  logic                        empty;
  logic                        first_neg;
  logic                        second_neg;
  logic                        out_valid;
  logic signed [CORR_BITS-1:0] out_corr;
  logic                        out_empty;

  logic                  pop;
  logic                  div_start;
  logic [SUM_BITS-1:0]   first_mag;
  logic [SUM_BITS-1:0]   second_mag;
  logic [NUM_BITS-1:0]   first_num;
  logic [NUM_BITS-1:0]   second_num;
  logic                  first_busy;
  logic                  second_busy;
  logic [NUM_BITS-1:0]   first_quo;
  logic [NUM_BITS-1:0]   second_quo;

  logic signed [NUM_BITS:0]    first_mean;
  logic signed [NUM_BITS:0]    second_mean;
  logic signed [NUM_BITS+1:0]  diff;
  logic signed [NUM_BITS+2:0]  scaled;
  logic signed [CORR_BITS-1:0] corr;
  logic                        emit;

  assign pop_ready = (state == S_ACCUM);
  assign pop       = pop_valid && pop_ready;
  assign div_start = (state == S_START) && (first_count != '0) && (second_count != '0);
  assign emit      = (state == S_EMIT) && (!out_valid || results.ready);

  // Each mean is |sum| * 256 / count, rounded to nearest with ties away from zero.
  always_comb begin
    first_mag  = first_sum[SUM_BITS-1] ? SUM_BITS'(-first_sum) : first_sum;
    second_mag = second_sum[SUM_BITS-1] ? SUM_BITS'(-second_sum) : second_sum;
    first_num  = {first_mag, {FRAC_BITS{1'b0}}} + NUM_BITS'(first_count >> 1);
    second_num = {second_mag, {FRAC_BITS{1'b0}}} + NUM_BITS'(second_count >> 1);
  end

  twc_div u_first_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (first_num),
    .divisor  (first_count),
    .busy     (first_busy),
    .quotient (first_quo)
  );

  twc_div u_second_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (second_num),
    .divisor  (second_count),
    .busy     (second_busy),
    .quotient (second_quo)
  );

  always_comb begin
    first_mean  = $signed({1'b0, first_quo});
    second_mean = $signed({1'b0, second_quo});
    if (first_neg)  first_mean  = -first_mean;
    if (second_neg) second_mean = -second_mean;
    diff   = (NUM_BITS + 2)'(first_mean) - (NUM_BITS + 2)'(second_mean);
    scaled = lockin ? $signed({diff, 1'b0}) : $signed({diff[NUM_BITS+1], diff});
    if ((scaled[NUM_BITS+2:CORR_BITS-1] == '0) || (scaled[NUM_BITS+2:CORR_BITS-1] == '1)) begin
      corr = scaled[CORR_BITS-1:0];
    end else begin
      corr = scaled[NUM_BITS+2] ? {1'b1, {(CORR_BITS-1){1'b0}}} : {1'b0, {(CORR_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_ACCUM;
      first_sum    <= '0;
      second_sum   <= '0;
      first_count  <= '0;
      second_count <= '0;
      lockin       <= 1'b0;
      empty        <= 1'b0;
      first_neg    <= 1'b0;
      second_neg   <= 1'b0;
    end else begin
      unique case (state)
        S_ACCUM: begin
          if (pop) begin
            // A window whose count is full ignores further samples.
            if (pop_data.first_hit && first_count != COUNT_MAX) begin
              first_sum   <= sat_add(first_sum, pop_data.value);
              first_count <= first_count + 1'b1;
            end
            if (pop_data.second_hit && second_count != COUNT_MAX) begin
              second_sum   <= sat_add(second_sum, pop_data.value);
              second_count <= second_count + 1'b1;
            end
            if (pop_data.last) begin
              lockin <= pop_data.lockin;
              state  <= S_START;
            end
          end
        end
        S_START: begin
          first_neg  <= first_sum[SUM_BITS-1];
          second_neg <= second_sum[SUM_BITS-1];
          empty      <= !div_start;
          state      <= div_start ? S_DIVIDE : S_EMIT;
        end
        S_DIVIDE: begin
          if (!first_busy && !second_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            first_sum    <= '0;
            second_sum   <= '0;
            first_count  <= '0;
            second_count <= '0;
            state        <= S_ACCUM;
          end
        end
        default: state <= S_ACCUM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_corr  <= empty ? '0 : corr;
      out_empty <= empty;
    end
  end

  assign results.valid        = out_valid;
  assign results.correlation  = out_corr;
  assign results.empty_window = out_empty;

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    first_busy == second_busy)
    else $error("window dividers out of step");

  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && first_count != '0 && second_count != '0)
      |=> (state == S_DIVIDE && first_busy))
    else $error("division not started for a filled transient");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (state == S_ACCUM && first_count == '0 && second_count == '0))
    else $error("accumulators not cleared after a result transfer");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_corr == '0))
    else $error("empty window result is not zero");
`endif

endmodule

### src/transient_window_correlator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator
// Double boxcar or lock-in weighting of one capacitance transient.
//
// The samples channel takes one sample per transfer with its time index; the
// last sample of a transient carries last_sample. The results channel gives
// one transfer per transient: the weighted mean difference with 8 fraction
// bits, or zero with empty_window set when either window saw no sample.
// Configuration is written through cfg_write/cfg_index/cfg_data between
// transients.
// Throughput: one sample per cycle while a transient is accumulated. After
// the last sample the back end takes no further sample until the result is
// emitted, while the two 48-bit window-mean divisions run side by side at one
// quotient bit per cycle; a transient with an empty window skips the
// divisions. The two-entry queue accepts up to two samples meanwhile and then
// stalls the input.
// The result is registered in the output register in the emit step, which
// follows the start step and, unless a window is empty, the divide step.
// Reset clears the accumulators and loads the register defaults. A stalled
// results receiver holds the result in the output register while the back
// end goes on accumulating; the next result then waits in the emit step and
// the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module transient_window_correlator_core import twc_pkg::*; #(
  parameter int BOXCAR_WIDTH = 10,
  parameter int SAMPLE_BITS  = 24,
  parameter int TIME_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]      cfg_data,
  twc_sample_if.sink                samples,
  twc_result_if.source              results
);

  logic       push_valid;
  logic       push_ready;
  twc_entry_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  twc_entry_t pop_data;

  twc_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TIME_BITS    (TIME_BITS),
    .BOXCAR_WIDTH (BOXCAR_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  twc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  twc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient window correlator testbench
// Feeds capacitance transients into the correlator under double boxcar and
// lock-in weighting and compares every result with a cycle-free predictor of
// the window sums, counts and rounded mean difference. Directed transients
// cover the window edges, the empty-window result and a reversed lock-in
// range; random transients follow with random pacing on both channels.
// ----------------------------------------------------------------------------
module tb;
  import twc_pkg::*;

  localparam int BOXCAR_WIDTH = 10;
  localparam int SAMPLE_BITS  = 24;
  localparam int TIME_BITS    = 16;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_ITEMS  = 450;
  localparam int HOLD_AFTER    = 12;
  localparam int HOLD_CYCLES   = 800;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint SUM_HI  = (64'sd1 <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO  = -SUM_HI - 1;
  localparam longint CORR_HI = (64'sd1 <<< (CORR_BITS - 1)) - 1;
  localparam longint CORR_LO = -CORR_HI - 1;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]          sample_time;
    logic                          last_sample;
    int unsigned                   gap;
  } sample_item_t;

  typedef struct {
    logic signed [CORR_BITS-1:0] correlation;
    logic                        empty_window;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [TIME_BITS-1:0]      cfg_data;

  twc_sample_if #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) samples_ch ();
  twc_result_if results_ch ();

  transient_window_correlator_core #(
    .BOXCAR_WIDTH(BOXCAR_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (samples_ch.sink),
    .results  (results_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sample_item_t pending_samples[$];
  corr_result_t expected_results[$];

  // Register copies and window accumulators of the predictor.
  logic                          reg_mode;
  logic [TIME_BITS-1:0]          reg_t1;
  logic [TIME_BITS-1:0]          reg_t2;
  logic signed [SUM_BITS-1:0]    win_sum [2];
  logic [COUNT_BITS-1:0]         win_count [2];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_count;
  int unsigned stall_left;
  int unsigned result_transfers;
  int unsigned random_items;
  bit          burst;

  function automatic int unsigned lockin_mid();
    int unsigned t1, t2;
    t1 = reg_t1;
    t2 = reg_t2;
    return (t2 >= t1) ? t1 + ((t2 - t1) >> 1) : t1;
  endfunction

  // Bit 0 set when the time index falls in the first window, bit 1 for the
  // second. Window ends are compared without wrapping the time range.
  function automatic logic [1:0] window_hits(logic [TIME_BITS-1:0] stamp);
    int unsigned t, t1, t2, mid;
    logic [1:0] hits;
    t = stamp;
    t1 = reg_t1;
    t2 = reg_t2;
    if (reg_mode == 1'b0) begin
      hits[0] = (t >= t1) && (t < t1 + BOXCAR_WIDTH);
      hits[1] = (t >= t2) && (t < t2 + BOXCAR_WIDTH);
    end else begin
      mid = lockin_mid();
      hits[0] = (t >= t1) && (t < mid);
      hits[1] = (t >= mid) && (t < t2);
    end
    return hits;
  endfunction

  function automatic longint window_mean_q8(longint sum, longint cnt);
    longint unsigned mag, q;
    mag = (sum < 0) ? longint'(-sum) : sum;
    q = (mag * 256 + longint'(cnt / 2)) / cnt;
    return (sum < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void absorb_sample(sample_item_t it);
    logic [1:0] hits;
    longint acc, diff;
    corr_result_t r;
    hits = window_hits(it.sample_time);
    for (int w = 0; w < 2; w++) begin
      if (hits[w] && win_count[w] != COUNT_MAX) begin
        acc = longint'(win_sum[w]) + longint'(it.sample_value);
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        win_sum[w] = SUM_BITS'(acc);
        win_count[w] = win_count[w] + 1'b1;
      end
    end
    if (!it.last_sample) return;
    if (win_count[0] == 0 || win_count[1] == 0) begin
      r.correlation = '0;
      r.empty_window = 1'b1;
    end else begin
      diff = window_mean_q8(win_sum[0], win_count[0]) - window_mean_q8(win_sum[1], win_count[1]);
      if (reg_mode) diff = diff * 2;
      if (diff > CORR_HI) diff = CORR_HI;
      if (diff < CORR_LO) diff = CORR_LO;
      r.correlation = CORR_BITS'(diff);
      r.empty_window = 1'b0;
    end
    expected_results.push_back(r);
    for (int w = 0; w < 2; w++) begin
      win_sum[w] = '0;
      win_count[w] = '0;
    end
  endfunction

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void queue_sample(logic signed [SAMPLE_BITS-1:0] v,
                                       logic [TIME_BITS-1:0] t, logic last,
                                       int unsigned gap);
    sample_item_t it;
    it.sample_value = v;
    it.sample_time = t;
    it.last_sample = last;
    it.gap = gap;
    pending_samples.push_back(it);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return SAMPLE_BITS'(int'($urandom_range(0, 600)) - 300);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Most times land in or just around a window; the rest anywhere.
  function automatic logic [TIME_BITS-1:0] pick_time();
    int unsigned lo, span, t1, t2;
    t1 = reg_t1;
    t2 = reg_t2;
    case ($urandom_range(0, 4))
      0: return TIME_BITS'($urandom);
      1, 2: lo = t1;
      default: lo = reg_mode ? lockin_mid() : t2;
    endcase
    if (reg_mode == 1'b0) span = BOXCAR_WIDTH;
    else span = (t2 >= t1) ? ((t2 - t1) >> 1) + 2 : 4;
    return TIME_BITS'(lo + $urandom_range(0, span + 3) - 2);
  endfunction

  // Sample driver: each item waits out its gap, then stays offered until taken.
  always @(posedge clk) begin
    sample_item_t head;
    if (rst) begin
      samples_ch.valid <= 1'b0;
      gap_count <= 0;
    end else if (!samples_ch.valid || samples_ch.ready) begin
      if (pending_samples.size() == 0) begin
        samples_ch.valid <= 1'b0;
      end else if (gap_count < pending_samples[0].gap) begin
        samples_ch.valid <= 1'b0;
        gap_count <= gap_count + 1;
      end else begin
        head = pending_samples.pop_front();
        samples_ch.sample_value <= head.sample_value;
        samples_ch.sample_time <= head.sample_time;
        samples_ch.last_sample <= head.last_sample;
        samples_ch.valid <= 1'b1;
        gap_count <= 0;
      end
    end
  end

  // Result receiver: a random stall after each transfer, and one long hold-off
  // so that the queue in front of the divider fills and the input stalls.
  always @(posedge clk) begin
    int unsigned stall;
    stall = stall_left;
    if (rst) begin
      results_ch.ready <= 1'b0;
      stall_left <= 0;
      result_transfers <= 0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        result_transfers <= result_transfers + 1;
        if (result_transfers + 1 == HOLD_AFTER) stall = HOLD_CYCLES;
        else if ($urandom_range(0, 3) == 0) stall = 0;
        else stall = $urandom_range(0, 12);
      end else if (stall != 0) begin
        stall = stall - 1;
      end
      stall_left <= stall;
      results_ch.ready <= (stall == 0);
    end
  end

  // Monitor: checks each result transfer, then predicts from each sample.
  always @(posedge clk) begin
    corr_result_t want;
    sample_item_t seen;
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: correlation %0d empty_window %0b",
                   $time, results_ch.correlation, results_ch.empty_window);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (results_ch.correlation !== want.correlation) begin
            $display("%0t: correlation expected %0d, got %0d",
                     $time, want.correlation, results_ch.correlation);
            mismatch_count++;
          end
          if (results_ch.empty_window !== want.empty_window) begin
            $display("%0t: empty_window expected %0b, got %0b",
                     $time, want.empty_window, results_ch.empty_window);
            mismatch_count++;
          end
        end
      end
      if (samples_ch.valid && samples_ch.ready) begin
        seen.sample_value = samples_ch.sample_value;
        seen.sample_time = samples_ch.sample_time;
        seen.last_sample = samples_ch.last_sample;
        seen.gap = 0;
        absorb_sample(seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || samples_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(logic m, logic [TIME_BITS-1:0] a,
                                   logic [TIME_BITS-1:0] b);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data <= TIME_BITS'(m);
    @(posedge clk);
    cfg_index <= REG_FIRST_TIME;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= REG_SECOND_TIME;
    cfg_data <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_mode = m;
    reg_t1 = a;
    reg_t2 = b;
    @(negedge clk);
  endtask

  task automatic run_random_phase();
    logic m;
    logic [TIME_BITS-1:0] a, b, t;
    int unsigned len;
    logic last;
    m = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: a = '0;
      1: a = TIME_BITS'(16'hFFFF - $urandom_range(0, 12));
      default: a = TIME_BITS'($urandom);
    endcase
    if (m == 1'b0) begin
      case ($urandom_range(0, 4))
        0: b = TIME_BITS'($urandom);
        1: b = 16'hFFFF;
        default: b = TIME_BITS'(a + $urandom_range(0, 30));
      endcase
    end else begin
      // Lock-in ranges include the reversed and the zero-length case.
      case ($urandom_range(0, 7))
        0: b = TIME_BITS'($urandom);
        1: b = a;
        2: b = TIME_BITS'(a - $urandom_range(1, 20));
        default: b = TIME_BITS'(a + $urandom_range(1, 60));
      endcase
    end
    program_registers(m, a, b);
    repeat ($urandom_range(2, 6)) begin
      len = $urandom_range(1, 24);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        t = pick_time();
        last = (k == len - 1);
        queue_sample(pick_value(), t, last, draw_gap());
        random_items++;
      end
    end
    wait_drained();
  endtask

  initial begin
    cfg_write = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    reg_mode = 1'b0;
    reg_t1 = FIRST_TIME_RESET;
    reg_t2 = SECOND_TIME_RESET;
    for (int w = 0; w < 2; w++) begin
      win_sum[w] = '0;
      win_count[w] = '0;
    end
    burst = 1'b0;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Boxcar windows at the reset times: window edges on both sides, the last
    // sample counted in its window, then two transients with an empty window.
    queue_sample(SAMPLE_MAX, 16'd100, 1'b0, draw_gap());
    queue_sample(SAMPLE_MIN, 16'd109, 1'b0, draw_gap());
    queue_sample(24'sd12345, 16'd110, 1'b0, draw_gap());
    queue_sample(24'sd777, 16'd99, 1'b0, draw_gap());
    queue_sample(-24'sd1, 16'd1000, 1'b0, draw_gap());
    queue_sample(24'sd5, 16'd1009, 1'b1, draw_gap());
    queue_sample(24'sd42, 16'd0, 1'b1, draw_gap());
    queue_sample(-24'sd5, 16'd105, 1'b1, draw_gap());
    wait_drained();

    // Lock-in with thirds that round down and away from zero.
    program_registers(1'b1, 16'd10, 16'd16);
    queue_sample(24'sd100, 16'd9, 1'b0, draw_gap());
    queue_sample(24'sd1, 16'd10, 1'b0, draw_gap());
    queue_sample(24'sd0, 16'd11, 1'b0, draw_gap());
    queue_sample(24'sd0, 16'd12, 1'b0, draw_gap());
    queue_sample(-24'sd2, 16'd13, 1'b0, draw_gap());
    queue_sample(24'sd0, 16'd14, 1'b0, draw_gap());
    queue_sample(24'sd100, 16'd16, 1'b0, draw_gap());
    queue_sample(24'sd0, 16'd15, 1'b1, draw_gap());
    wait_drained();

    // Boxcar windows running past the top of the time range.
    program_registers(1'b0, 16'd65530, 16'hFFFF);
    queue_sample(24'sd3, 16'hFFFF, 1'b0, draw_gap());
    queue_sample(SAMPLE_MIN, 16'd65530, 1'b0, draw_gap());
    queue_sample(24'sd7, 16'd65529, 1'b0, draw_gap());
    queue_sample(24'sd1, 16'd0, 1'b1, draw_gap());
    wait_drained();

    // Lock-in with the second time below the first, then both times equal.
    program_registers(1'b1, 16'd500, 16'd100);
    queue_sample(24'sd5, 16'd300, 1'b0, draw_gap());
    queue_sample(24'sd6, 16'd500, 1'b0, draw_gap());
    queue_sample(24'sd7, 16'd50, 1'b1, draw_gap());
    wait_drained();
    program_registers(1'b1, 16'd200, 16'd200);
    queue_sample(24'sd1, 16'd200, 1'b1, draw_gap());
    wait_drained();

    while (random_items < RANDOM_ITEMS) run_random_phase();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
